@@ rtl/apq_pkg.sv @@
// ----------------------------------------------------------------------------
// Array priority queue package
// Operation codes, status codes and the sequencer state type shared by the
// priority queue RTL.
// ----------------------------------------------------------------------------
package apq_pkg;

    localparam int DATA_W    = 32;
    localparam int HELD_W    = 5;
    localparam int OPCODE_W  = 2;
    localparam int STATUS_W  = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

endpackage

@@ rtl/array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Array priority queue
// Bounded priority queue held as an unsorted array in arrival order, with
// push, pop-highest and peek-highest operations and one result beat each.
// ----------------------------------------------------------------------------
// One operation is taken at a time and every operation returns one result
// beat. A push or an operation on an empty queue goes straight from the input
// beat to the result state. A peek scans the held entries through the single
// read port of the entry memory, one entry a cycle. A pop runs the same scan
// and then moves every later entry down one slot through the same read and
// write ports, one entry a cycle; the move is skipped when the selected entry
// is the last one held. The input channel opens again once the result sits in
// the output register, so a new operation can start while the previous result
// waits to be taken. Priorities are signed; among equal priorities the
// earliest entry is selected.
// ----------------------------------------------------------------------------
module array_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [apq_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic signed [apq_pkg::DATA_W-1:0]    s_item_data,
    input  logic signed [apq_pkg::DATA_W-1:0]    s_item_priority,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [apq_pkg::STATUS_W-1:0]  m_status,
    output logic signed [apq_pkg::DATA_W-1:0]    m_out_data,
    output logic signed [apq_pkg::DATA_W-1:0]    m_out_priority,
    output logic        [apq_pkg::HELD_W-1:0]    m_entries_held,
    output logic                                 m_is_full
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = apq_pkg::DATA_W;
    localparam int MW = 2 * DW;

    logic [MW-1:0] entry_mem [CAPACITY];

    apq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                   occ_reg, occ_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [CW-1:0]                   pend_idx_reg, pend_idx_next;
    logic [CW-1:0]                   best_idx_reg, best_idx_next;
    logic signed [DW-1:0]            best_pri_reg, best_pri_next;
    logic signed [DW-1:0]            best_dat_reg, best_dat_next;
    logic                            pop_reg, pop_next;
    logic [apq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [MW-1:0]                   rd_data_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [apq_pkg::STATUS_W-1:0]    m_status_reg, m_status_next;
    logic signed [DW-1:0]            m_data_reg, m_data_next;
    logic signed [DW-1:0]            m_pri_reg, m_pri_next;
    logic [apq_pkg::HELD_W-1:0]      m_held_reg, m_held_next;
    logic                            m_full_reg, m_full_next;

    logic                            mem_we;
    logic [IW-1:0]                   mem_wa;
    logic [MW-1:0]                   mem_wd;

    logic                            acc;
    logic                            out_free;
    logic                            issue;
    logic                            take;
    logic                            last_beat;
    logic                            tail_sel;
    logic                            push_ok;
    logic [CW-1:0]                   occ_last;
    logic [CW-1:0]                   sel_idx;
    logic signed [DW-1:0]            cand_pri;
    logic signed [DW-1:0]            cand_dat;
    logic [CW+apq_pkg::HELD_W-1:0]   occ_wide;

    assign s_ready  = (state_reg == apq_pkg::S_IDLE);
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign occ_last  = occ_reg - CW'(1);
    assign issue     = (idx_reg < occ_reg);
    assign cand_pri  = rd_data_reg[DW-1:0];
    assign cand_dat  = rd_data_reg[MW-1:DW];
    assign take      = pend_reg && ((pend_idx_reg == '0) || (cand_pri > best_pri_reg));
    assign sel_idx   = take ? pend_idx_reg : best_idx_reg;
    assign last_beat = pend_reg && (pend_idx_reg == occ_last);
    assign tail_sel  = (sel_idx == occ_last);
    assign push_ok   = (occ_reg < CW'(CAPACITY));
    assign occ_wide  = {{apq_pkg::HELD_W{1'b0}}, occ_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            apq_pkg::S_IDLE: begin
                if (acc) begin
                    if (((s_opcode == apq_pkg::OP_POP) || (s_opcode == apq_pkg::OP_PEEK))
                        && (occ_reg != '0)) begin
                        state_next = apq_pkg::S_SCAN;
                    end else begin
                        state_next = apq_pkg::S_RESP;
                    end
                end
            end
            apq_pkg::S_SCAN: begin
                if (last_beat) begin
                    state_next = (pop_reg && !tail_sel) ? apq_pkg::S_SHIFT : apq_pkg::S_RESP;
                end
            end
            apq_pkg::S_SHIFT: begin
                if (last_beat) begin
                    state_next = apq_pkg::S_RESP;
                end
            end
            apq_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = apq_pkg::S_IDLE;
                end
            end
            default: state_next = apq_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        best_idx_next = best_idx_reg;
        best_pri_next = best_pri_reg;
        best_dat_next = best_dat_reg;
        pop_next      = pop_reg;
        status_next   = status_reg;
        mem_we        = 1'b0;
        mem_wa        = pend_idx_reg[IW-1:0] - IW'(1);
        mem_wd        = rd_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_pri_next    = m_pri_reg;
        m_held_next   = m_held_reg;
        m_full_next   = m_full_reg;

        unique case (state_reg)
            apq_pkg::S_IDLE: begin
                if (acc) begin
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    best_pri_next = '0;
                    best_dat_next = '0;
                    pop_next      = (s_opcode == apq_pkg::OP_POP);
                    status_next   = apq_pkg::ST_OK;
                    unique case (s_opcode)
                        apq_pkg::OP_PUSH: begin
                            if (push_ok) begin
                                mem_we   = 1'b1;
                                mem_wa   = occ_reg[IW-1:0];
                                mem_wd   = {s_item_data, s_item_priority};
                                occ_next = occ_reg + CW'(1);
                            end else begin
                                status_next = apq_pkg::ST_FULL;
                            end
                        end
                        apq_pkg::OP_POP, apq_pkg::OP_PEEK: begin
                            if (occ_reg == '0) begin
                                status_next = apq_pkg::ST_EMPTY;
                            end
                        end
                        default: status_next = apq_pkg::ST_OK;
                    endcase
                end
            end
            apq_pkg::S_SCAN: begin
                pend_next     = issue;
                pend_idx_next = idx_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (take) begin
                    best_idx_next = pend_idx_reg;
                    best_pri_next = cand_pri;
                    best_dat_next = cand_dat;
                end
                if (last_beat && pop_reg) begin
                    if (tail_sel) begin
                        occ_next = occ_last;
                    end else begin
                        idx_next  = sel_idx + CW'(1);
                        pend_next = 1'b0;
                    end
                end
            end
            apq_pkg::S_SHIFT: begin
                pend_next     = issue;
                pend_idx_next = idx_reg;
                if (issue) begin
                    idx_next = idx_reg + CW'(1);
                end
                if (pend_reg) begin
                    mem_we = 1'b1;
                end
                if (last_beat) begin
                    occ_next = occ_last;
                end
            end
            apq_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_data_next   = best_dat_reg;
                    m_pri_next    = best_pri_reg;
                    m_held_next   = occ_wide[apq_pkg::HELD_W-1:0];
                    m_full_next   = (occ_reg == CW'(CAPACITY));
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apq_pkg::S_IDLE;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        best_idx_reg <= best_idx_next;
        best_pri_reg <= best_pri_next;
        best_dat_reg <= best_dat_next;
        pop_reg      <= pop_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_pri_reg    <= m_pri_next;
        m_held_reg   <= m_held_next;
        m_full_reg   <= m_full_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= entry_mem[idx_reg[IW-1:0]];
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_data     = m_data_reg;
    assign m_out_priority = m_pri_reg;
    assign m_entries_held = m_held_reg;
    assign m_is_full      = m_full_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CW'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CW'(mem_wa) <= occ_reg))
        else $error("Entry write outside the held range.");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == apq_pkg::ST_EMPTY)) |-> (m_entries_held == '0))
        else $error("Empty status reported with entries held.");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_full) |-> (m_status != apq_pkg::ST_EMPTY))
        else $error("Full queue reported as empty.");
`endif

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Array priority queue testbench
// Drives push, pop, peek and the unused opcode into the queue with bursty
// input beats and a stalling result side, predicts every result beat from a
// shadow copy of the queue and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 64;

    localparam int OPCODE_W = apq_pkg::OPCODE_W;
    localparam int DATA_W   = apq_pkg::DATA_W;
    localparam int STATUS_W = apq_pkg::STATUS_W;
    localparam int HELD_W   = apq_pkg::HELD_W;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
        logic                     drain_first;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
        logic [HELD_W-1:0]        held;
        logic                     full;
    } result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OPCODE_W-1:0]        s_opcode = '0;
    logic signed [DATA_W-1:0]   s_item_data = '0;
    logic signed [DATA_W-1:0]   s_item_priority = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [DATA_W-1:0]   m_out_data;
    logic signed [DATA_W-1:0]   m_out_priority;
    logic [HELD_W-1:0]          m_entries_held;
    logic                       m_is_full;

    op_t     op_backlog[$];
    result_t pending_results[$];

    logic signed [DATA_W-1:0] held_data [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] held_prio [QUEUE_DEPTH];
    int held_count = 0;

    int beats_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    int n_push = 0, n_refused = 0, n_pop = 0, n_peek = 0, n_unused = 0, n_empty = 0;
    int n_reached_full = 0;

    array_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_item_data(s_item_data),
        .s_item_priority(s_item_priority),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_out_data(m_out_data),
        .m_out_priority(m_out_priority),
        .m_entries_held(m_entries_held),
        .m_is_full(m_is_full)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic result_t serve_operation(op_t op);
        result_t r;
        int best;
        int i;
        r = '0;
        case (op.opcode)
            apq_pkg::OP_PUSH: begin
                n_push++;
                if (held_count >= QUEUE_DEPTH) begin
                    r.status = apq_pkg::ST_FULL;
                    n_refused++;
                end else begin
                    held_data[held_count] = op.data;
                    held_prio[held_count] = op.prio;
                    held_count++;
                    if (held_count == QUEUE_DEPTH) n_reached_full++;
                end
            end
            apq_pkg::OP_POP, apq_pkg::OP_PEEK: begin
                if (op.opcode == apq_pkg::OP_POP) n_pop++;
                else n_peek++;
                if (held_count == 0) begin
                    r.status = apq_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    best = 0;
                    for (i = 1; i < held_count; i++) begin
                        if (held_prio[i] > held_prio[best]) best = i;
                    end
                    r.data = held_data[best];
                    r.prio = held_prio[best];
                    if (op.opcode == apq_pkg::OP_POP) begin
                        for (i = best; i < held_count - 1; i++) begin
                            held_data[i] = held_data[i + 1];
                            held_prio[i] = held_prio[i + 1];
                        end
                        held_count--;
                    end
                end
            end
            OP_UNUSED: n_unused++;
            default: ;
        endcase
        r.held = held_count[HELD_W-1:0];
        r.full = (held_count == QUEUE_DEPTH);
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 5))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return $urandom_range(0, 6) - 3;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_data();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
        end
        return $urandom();
    endfunction

    task automatic queue_op(logic [OPCODE_W-1:0] opcode, logic signed [DATA_W-1:0] data,
                            logic signed [DATA_W-1:0] prio, logic drain_first);
        op_t op;
        op.opcode = opcode;
        op.data = data;
        op.prio = prio;
        op.drain_first = drain_first;
        op_backlog.push_back(op);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : driver
        op_t next_op;
        int burst_left;
        int gap_left;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                next_op.opcode = s_opcode;
                next_op.data = s_item_data;
                next_op.prio = s_item_priority;
                next_op.drain_first = 1'b0;
                pending_results.push_back(serve_operation(next_op));
                beats_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (op_backlog.size() > 0 &&
                             !(op_backlog[0].drain_first && beats_sent != results_seen)) begin
                    next_op = op_backlog.pop_front();
                    s_opcode <= next_op.opcode;
                    s_item_data <= next_op.data;
                    s_item_priority <= next_op.prio;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        result_t want;
        int ready_mode;
        int mode_left;
        int stall_phase;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        stall_phase++;
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= (stall_phase % 8 == 0);
        endcase
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat expected none, got status %0d data %h", $time,
                         m_status, m_out_data);
            end else begin
                want = pending_results.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(m_status));
                check_field("out_data", want.data, m_out_data);
                check_field("out_priority", want.prio, m_out_priority);
                check_field("entries_held", DATA_W'(want.held), DATA_W'(m_entries_held));
                check_field("is_full", DATA_W'(want.full), DATA_W'(m_is_full));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int made;
        int len;
        int kind;
        int r;
        logic [OPCODE_W-1:0] opcode;

        queue_op(apq_pkg::OP_PEEK, WORD_MAX, WORD_MIN, 1'b0);
        queue_op(apq_pkg::OP_POP, WORD_MIN, WORD_MAX, 1'b0);
        queue_op(OP_UNUSED, WORD_MIN, WORD_MIN, 1'b0);
        queue_op(apq_pkg::OP_PUSH, WORD_MAX, WORD_MIN, 1'b0);
        queue_op(apq_pkg::OP_PUSH, WORD_MIN, WORD_MIN, 1'b0);
        queue_op(apq_pkg::OP_PEEK, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_PEEK, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_PUSH, 0, WORD_MAX, 1'b0);
        queue_op(apq_pkg::OP_PUSH, -1, -1, 1'b0);
        queue_op(apq_pkg::OP_PUSH, 1, WORD_MAX, 1'b0);
        queue_op(apq_pkg::OP_PUSH, 32'h5555_5555, 0, 1'b0);
        queue_op(OP_UNUSED, WORD_MAX, WORD_MAX, 1'b0);
        queue_op(apq_pkg::OP_PEEK, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_POP, 0, 0, 1'b0);
        queue_op(apq_pkg::OP_PEEK, 0, 0, 1'b0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            len = (kind <= 4) ? $urandom_range(10, 40) :
                  (kind <= 6) ? $urandom_range(14, 20) : $urandom_range(1, 18);
            for (int k = 0; k < len; k++) begin
                if (kind <= 4) begin
                    r = $urandom_range(0, 19);
                    opcode = (r < 9) ? apq_pkg::OP_PUSH :
                             (r < 15) ? apq_pkg::OP_POP :
                             (r < 19) ? apq_pkg::OP_PEEK : OP_UNUSED;
                end else if (kind <= 6 || kind == 9) begin
                    opcode = ($urandom_range(0, 9) == 0) ? apq_pkg::OP_PEEK
                                                         : apq_pkg::OP_PUSH;
                end else if (kind == 7) begin
                    opcode = ($urandom_range(0, 7) == 0) ? apq_pkg::OP_PEEK
                                                         : apq_pkg::OP_POP;
                end else begin
                    opcode = (k < len / 2) ? apq_pkg::OP_PUSH : apq_pkg::OP_POP;
                end
                queue_op(opcode, pick_data(), pick_priority(),
                         made == 0 || made == RANDOM_ITEMS / 2);
                made++;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (op_backlog.size() != 0 || s_valid || beats_sent != results_seen) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            error_count += pending_results.size();
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        $display("Covered %0d pushes (%0d refused while full, queue filled %0d times), %0d pops,",
                 n_push, n_refused, n_reached_full, n_pop);
        $display("%0d peeks, %0d unused opcodes, %0d empty-queue hits; %0d results checked.",
                 n_peek, n_unused, n_empty, results_seen);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/apq_pkg.sv
rtl/array_priority_queue.sv
test/testbench.sv
